### rtl/core/wgm_pkg.sv
// ----------------------------------------------------------------------------
// wgm_pkg: shared types for the glob matcher
// Word layouts, item kinds, cell commands and pattern symbols.
// ----------------------------------------------------------------------------
package wgm_pkg;

    typedef enum logic [1:0] {
        KIND_START   = 2'd0,
        KIND_APPEND  = 2'd1,
        KIND_SUBJECT = 2'd2,
        KIND_END     = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] symbol;
    } in_word_t;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } out_word_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_REARM,
        OP_WRITE,
        OP_CLOSE,
        OP_CONSUME
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] symbol;
    } ctrl_t;

    localparam logic [7:0] STAR_SYM = 8'h2A;
    localparam logic [7:0] ANY_SYM  = 8'h3F;

endpackage

### rtl/core/wildcard_glob_matcher.sv
// ----------------------------------------------------------------------------
// wildcard_glob_matcher: streaming glob matcher with '*' and '?'
// Pattern bytes load into a row of cells; subject bytes step an active vector.
// ----------------------------------------------------------------------------
// Kinds start and append go from idle to an execute state and back to idle.
// A subject byte or an end marker first passes through a close state, where
// the star closure ripples through the cell row: it advances one cell per
// cycle and repeats until a pass changes nothing; the item then executes.
// An end marker also waits in the execute state while the result
// register still holds an untaken word.
module wildcard_glob_matcher #(
    parameter int PATTERN_CAPACITY = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  wgm_pkg::in_word_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output wgm_pkg::out_word_t   m_data
);

    localparam int LEN_W = $clog2(PATTERN_CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_EXEC
    } state_t;

    state_t             state_reg, state_next;
    wgm_pkg::in_word_t  item_reg, item_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               ovf_reg, ovf_next;
    logic               m_valid_reg, m_valid_next;
    wgm_pkg::out_word_t m_data_reg, m_data_next;
    logic               last_reg, last_next;

    wgm_pkg::ctrl_t              ctrl;
    logic [PATTERN_CAPACITY:0]   carry;
    logic [PATTERN_CAPACITY:0]   act_all;
    logic [PATTERN_CAPACITY-1:0] cell_changed;
    logic                        any_change;
    logic                        out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign carry[0] = 1'b0;

    genvar p;
    generate
        for (p = 0; p < PATTERN_CAPACITY; p++) begin : g_cell
            wgm_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .head       ((p == 0) ? 1'b1 : 1'b0),
                .in_pattern (LEN_W'(p) < len_reg),
                .write_en   ((ctrl.op == wgm_pkg::OP_WRITE) && (len_reg == LEN_W'(p))),
                .carry_in   (carry[p]),
                .carry_out  (carry[p+1]),
                .active     (act_all[p]),
                .changed    (cell_changed[p])
            );
        end
    endgenerate

    assign act_all[PATTERN_CAPACITY] = last_reg;
    assign any_change = (|cell_changed) || (carry[PATTERN_CAPACITY] && !last_reg);

    always_comb begin
        ctrl.symbol = item_reg.symbol;
        ctrl.op     = wgm_pkg::OP_NONE;
        unique case (state_reg)
            ST_CLOSE: ctrl.op = wgm_pkg::OP_CLOSE;
            ST_EXEC: begin
                unique case (item_reg.kind)
                    wgm_pkg::KIND_START:   ctrl.op = wgm_pkg::OP_REARM;
                    wgm_pkg::KIND_APPEND:  ctrl.op = wgm_pkg::OP_WRITE;
                    wgm_pkg::KIND_SUBJECT: ctrl.op = wgm_pkg::OP_CONSUME;
                    default: ctrl.op = out_free ? wgm_pkg::OP_REARM : wgm_pkg::OP_NONE;
                endcase
            end
            default: ctrl.op = wgm_pkg::OP_NONE;
        endcase
    end

    always_comb begin
        unique case (ctrl.op)
            wgm_pkg::OP_REARM:   last_next = 1'b0;
            wgm_pkg::OP_CLOSE:   last_next = last_reg | carry[PATTERN_CAPACITY];
            wgm_pkg::OP_CONSUME: last_next = carry[PATTERN_CAPACITY];
            default:             last_next = last_reg;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        len_next     = len_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;
        m_data_next  = m_data_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next = s_data;
                    if (s_data.kind == wgm_pkg::KIND_SUBJECT ||
                        s_data.kind == wgm_pkg::KIND_END) begin
                        state_next = ST_CLOSE;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_CLOSE: begin
                if (!any_change) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_IDLE;
                unique case (item_reg.kind)
                    wgm_pkg::KIND_START: begin
                        len_next = '0;
                        ovf_next = 1'b0;
                    end
                    wgm_pkg::KIND_APPEND: begin
                        if (len_reg < LEN_W'(PATTERN_CAPACITY)) begin
                            len_next = len_reg + 1'b1;
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                    wgm_pkg::KIND_SUBJECT: begin
                    end
                    default: begin
                        if (out_free) begin
                            m_valid_next                 = 1'b1;
                            m_data_next.matched          = act_all[len_reg] && !ovf_reg;
                            m_data_next.pattern_overflow = ovf_reg;
                        end else begin
                            state_next = ST_EXEC;
                        end
                    end
                endcase
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            last_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
            last_reg    <= last_next;
        end
        item_reg   <= item_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### rtl/core/wgm_cell.sv
// ----------------------------------------------------------------------------
// wgm_cell: one pattern position
// Holds one pattern symbol and its active bit; passes a carry to the next cell.
// ----------------------------------------------------------------------------
module wgm_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  wgm_pkg::ctrl_t ctrl,
    input  logic          head,
    input  logic          in_pattern,
    input  logic          write_en,
    input  logic          carry_in,
    output logic          carry_out,
    output logic          active,
    output logic          changed
);

    logic [7:0] sym_reg;
    logic       act_reg;
    logic       act_next;
    logic       is_star;
    logic       sym_hit;
    logic       keep;

    assign is_star = (sym_reg == wgm_pkg::STAR_SYM);
    assign sym_hit = (sym_reg == wgm_pkg::ANY_SYM) || (sym_reg == ctrl.symbol);
    assign keep    = act_reg && in_pattern && is_star;

    always_comb begin
        if (ctrl.op == wgm_pkg::OP_CLOSE) begin
            carry_out = keep;
        end else begin
            carry_out = act_reg && in_pattern && !is_star && sym_hit;
        end
    end

    always_comb begin
        unique case (ctrl.op)
            wgm_pkg::OP_REARM:   act_next = head;
            wgm_pkg::OP_CLOSE:   act_next = act_reg | carry_in;
            wgm_pkg::OP_CONSUME: act_next = keep | carry_in;
            default:             act_next = act_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= head;
        end else begin
            act_reg <= act_next;
        end
        if (write_en) begin
            sym_reg <= ctrl.symbol;
        end
    end

    assign active  = act_reg;
    assign changed = carry_in && !act_reg;

endmodule
